[rtl/mfb_pkg.sv]
`default_nettype none
// ============================================================================
// mfb_pkg: shared definitions for the one-bit frame store
// Store geometry, tile geometry, operation and register codes, controller
// states and the command and status bundles between controller and datapath.
// ============================================================================
package mfb_pkg;

    // Screen, tile and word geometry.
    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 64;
    localparam int TILE_W     = 32;
    localparam int TILE_H     = 16;
    localparam int WORD_BITS  = 16;

    localparam int ELEMS_X     = (SCREEN_W + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_DEPTH = ELEMS_X * SCREEN_H;
    localparam int TILE_WORDS  = TILE_W / WORD_BITS;
    localparam int TCOLS_MAX   = SCREEN_W / TILE_W;
    localparam int TROWS_MAX   = SCREEN_H / TILE_H;

    // Derived widths.
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int XIDX_W   = $clog2(ELEMS_X);
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int YADDR_W  = $clog2(SCREEN_H);
    localparam int TCNT_W   = $clog2(TCOLS_MAX + 1);
    localparam int RCNT_W   = $clog2(TROWS_MAX + 1);
    localparam int TCOL_W   = $clog2(TCOLS_MAX);
    localparam int TROW_W   = $clog2(TROWS_MAX);
    localparam int LINE_W   = $clog2(TILE_H);
    localparam int K_W      = $clog2(TILE_WORDS);

    // Field widths of the ports.
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 8;
    localparam int COLOR_W   = 16;
    localparam int WIDTH_W   = 8;
    localparam int HEIGHT_W  = 7;
    localparam int TIDX_W    = 4;
    localparam int ROWBITS_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [WORD_BITS-1:0] WORD_MASK   = '1;
    localparam logic [COLOR_W-1:0]   FRONT_RESET = 16'h8000;

    // Result kinds.
    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET   = 2'd0,
        FUNC_FILL  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USED_WIDTH  = 2'd0,
        CFG_USED_HEIGHT = 2'd1,
        CFG_FRONT_LEVEL = 2'd2
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_WR,
        S_RD_OUT,
        S_FILL,
        S_FL_READ,
        S_FL_CMP,
        S_FL_COPY,
        S_FL_EMIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take_item;
        logic clr_wr;
        logic fill_wr;
        logic sweep_inc;
        logic set_wr;
        logic rd_load;
        logic fl_start;
        logic fl_rd;
        logic fl_cmp;
        logic word_step;
        logic copy_wr;
        logic line_next;
        logic emit_load;
        logic tile_next;
        logic flush_done;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic sweep_last;
        logic word_last;
        logic line_last;
        logic tile_last;
        logic diff_now;
        logic out_free;
        logic no_tiles;
    } t_status;

endpackage
`default_nettype wire

[rtl/mfb_ctrl.sv]
`default_nettype none
// ============================================================================
// mfb_ctrl: sequencer of the one-bit frame store
// Walks the clearing pass, pixel read-modify-write, fill sweep, row reads and
// the tile-by-tile flush scan, and drives the datapath by commands.
// ============================================================================
module mfb_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [mfb_pkg::FUNC_W-1:0]    i_func,
    output logic                               o_stall,
    input  wire mfb_pkg::t_status              i_status,
    output mfb_pkg::t_cmd                      o_cmd
);
    import mfb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_func'(i_func))
                        FUNC_SET:   n_state = S_SET_WR;
                        FUNC_FILL:  n_state = S_FILL;
                        FUNC_FLUSH: n_state = i_status.no_tiles ? S_IDLE : S_FL_READ;
                        FUNC_READ:  n_state = S_RD_OUT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SET_WR: n_state = S_IDLE;
            S_RD_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_FILL: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_FL_READ: n_state = S_FL_CMP;
            S_FL_CMP: begin
                if (!i_status.word_last) begin
                    n_state = S_FL_READ;
                end else if (i_status.diff_now) begin
                    n_state = S_FL_COPY;
                end else begin
                    n_state = i_status.line_last ? S_FL_EMIT : S_FL_READ;
                end
            end
            S_FL_COPY: begin
                if (i_status.word_last) begin
                    n_state = i_status.line_last ? S_FL_EMIT : S_FL_READ;
                end
            end
            S_FL_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.tile_last ? S_IDLE : S_FL_READ;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr    = 1'b1;
                o_cmd.sweep_inc = 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take_item = 1'b1;
                    if (t_func'(i_func) == FUNC_FLUSH) begin
                        o_cmd.fl_start   = 1'b1;
                        o_cmd.flush_done = i_status.no_tiles;
                    end
                end
            end
            S_SET_WR: o_cmd.set_wr = 1'b1;
            S_RD_OUT: o_cmd.rd_load = i_status.out_free;
            S_FILL: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.sweep_inc = 1'b1;
            end
            S_FL_READ: o_cmd.fl_rd = 1'b1;
            S_FL_CMP: begin
                o_cmd.fl_cmp    = 1'b1;
                o_cmd.word_step = 1'b1;
                o_cmd.line_next = i_status.word_last && !i_status.diff_now;
            end
            S_FL_COPY: begin
                o_cmd.copy_wr   = 1'b1;
                o_cmd.word_step = 1'b1;
                o_cmd.line_next = i_status.word_last;
            end
            S_FL_EMIT: begin
                o_cmd.emit_load  = i_status.out_free;
                o_cmd.tile_next  = i_status.out_free;
                o_cmd.flush_done = i_status.out_free && i_status.tile_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/mfb_dpath.sv]
`default_nettype none
// ============================================================================
// mfb_dpath: storage and datapath of the one-bit frame store
// Holds the frame and shadow memories, the configuration registers, the
// captured item, the flush scan counters and the output register.
// ============================================================================
module mfb_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write
    input  wire logic                            i_cfg_valid,
    input  wire logic [mfb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mfb_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // Input item fields
    input  wire logic [mfb_pkg::POS_W-1:0]       i_x_pos,
    input  wire logic [mfb_pkg::POS_W-1:0]       i_y_pos,
    input  wire logic [mfb_pkg::COLOR_W-1:0]     i_color,
    // Output channel
    input  wire logic                            i_stall,
    output logic                                 o_valid,
    output logic                                 o_kind,
    output logic [mfb_pkg::TIDX_W-1:0]           o_tile_col,
    output logic [mfb_pkg::TIDX_W-1:0]           o_tile_row,
    output logic                                 o_needs_write,
    output logic [mfb_pkg::ROWBITS_W-1:0]        o_row_bits,
    output logic                                 o_last,
    // Controller link
    input  wire mfb_pkg::t_cmd                   i_cmd,
    output mfb_pkg::t_status                     o_status
);
    import mfb_pkg::*;

    // Memories.
    logic [WORD_BITS-1:0] frame_mem  [STORE_DEPTH];
    logic [WORD_BITS-1:0] shadow_mem [STORE_DEPTH];
    logic [WORD_BITS-1:0] r_frame_q;
    logic [WORD_BITS-1:0] r_shadow_q;

    // Configuration.
    logic [WIDTH_W-1:0]  r_used_width;
    logic [HEIGHT_W-1:0] r_used_height;
    logic [COLOR_W-1:0]  r_front_level;

    // Captured item.
    logic [ADDR_W-1:0] r_addr;
    logic [BIT_W-1:0]  r_bit;
    logic              r_on;
    logic              r_inside;
    logic              r_rd_inside;

    // Sweep and flush scan state.
    logic [ADDR_W-1:0]    r_sweep;
    logic [TCOL_W-1:0]    r_tcol;
    logic [TROW_W-1:0]    r_trow;
    logic [LINE_W-1:0]    r_line;
    logic [K_W-1:0]       r_k;
    logic                 r_line_diff;
    logic                 r_changed;
    logic                 r_flushed_once;
    logic [WORD_BITS-1:0] r_buf [TILE_WORDS];

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [TIDX_W-1:0]    r_out_tcol;
    logic [TIDX_W-1:0]    r_out_trow;
    logic                 r_out_nw;
    logic [ROWBITS_W-1:0] r_out_bits;
    logic                 r_out_last;

    logic [TCNT_W-1:0]    tile_cols;
    logic [RCNT_W-1:0]    tile_rows;
    logic                 col_last;
    logic                 row_last;
    logic                 word_last;
    logic                 line_last;
    logic                 sweep_last;
    logic                 diff_now;
    logic                 out_free;
    logic [ADDR_W-1:0]    port_addr;
    logic [YADDR_W-1:0]   fl_y;
    logic [XIDX_W-1:0]    fl_w;
    logic [ADDR_W-1:0]    fl_addr;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] set_word;
    logic                 frame_we;
    logic                 frame_re;
    logic [ADDR_W-1:0]    frame_waddr;
    logic [ADDR_W-1:0]    frame_raddr;
    logic [WORD_BITS-1:0] frame_wdata;
    logic                 shadow_we;
    logic [ADDR_W-1:0]    shadow_waddr;
    logic [WORD_BITS-1:0] shadow_wdata;

    // Whole tiles of the used area; tile sizes are powers of two.
    assign tile_cols = TCNT_W'(r_used_width / WIDTH_W'(TILE_W));
    assign tile_rows = RCNT_W'(r_used_height / HEIGHT_W'(TILE_H));

    assign col_last   = (TCNT_W'(r_tcol) + TCNT_W'(1)) == tile_cols;
    assign row_last   = (RCNT_W'(r_trow) + RCNT_W'(1)) == tile_rows;
    assign word_last  = (r_k == K_W'(TILE_WORDS - 1));
    assign line_last  = (r_line == LINE_W'(TILE_H - 1));
    assign sweep_last = (r_sweep == ADDR_W'(STORE_DEPTH - 1));
    assign diff_now   = r_line_diff || (r_frame_q != r_shadow_q);
    assign out_free   = !r_out_valid || !i_stall;

    always_comb begin
        o_status            = '0;
        o_status.sweep_last = sweep_last;
        o_status.word_last  = word_last;
        o_status.line_last  = line_last;
        o_status.tile_last  = col_last && row_last;
        o_status.diff_now   = diff_now;
        o_status.out_free   = out_free;
        o_status.no_tiles   = (tile_cols == '0) || (tile_rows == '0);
    end

    // Word address of the item's pixel, and of the word under the flush scan.
    assign port_addr = ADDR_W'(ADDR_W'(i_y_pos[YADDR_W-1:0]) * ADDR_W'(ELEMS_X))
                     + ADDR_W'(i_x_pos[XIDX_W+BIT_W-1:BIT_W]);
    assign fl_y      = YADDR_W'(YADDR_W'(r_trow) * YADDR_W'(TILE_H)) + YADDR_W'(r_line);
    assign fl_w      = XIDX_W'(XIDX_W'(r_tcol) * XIDX_W'(TILE_WORDS)) + XIDX_W'(r_k);
    assign fl_addr   = ADDR_W'(ADDR_W'(fl_y) * ADDR_W'(ELEMS_X)) + ADDR_W'(fl_w);

    // Pixel update of the word read in the accept cycle.
    assign bit_mask = WORD_BITS'(1) << r_bit;
    assign set_word = r_on ? (r_frame_q | bit_mask) : (r_frame_q & ~bit_mask);

    // Frame memory port selection.
    assign frame_we    = i_cmd.clr_wr || i_cmd.fill_wr || (i_cmd.set_wr && r_inside);
    assign frame_waddr = i_cmd.set_wr ? r_addr : r_sweep;
    assign frame_wdata = i_cmd.set_wr ? set_word : (i_cmd.fill_wr ? WORD_MASK : '0);
    assign frame_re    = i_cmd.take_item || i_cmd.fl_rd;
    assign frame_raddr = i_cmd.fl_rd ? fl_addr : port_addr;

    // Shadow memory port selection.
    assign shadow_we    = i_cmd.clr_wr || i_cmd.copy_wr;
    assign shadow_waddr = i_cmd.copy_wr ? fl_addr : r_sweep;
    assign shadow_wdata = i_cmd.copy_wr ? r_buf[r_k] : '0;

    // Frame memory.
    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            r_frame_q <= frame_mem[frame_raddr];
        end
    end

    // Shadow memory.
    always_ff @(posedge i_clk) begin
        if (shadow_we) begin
            shadow_mem[shadow_waddr] <= shadow_wdata;
        end
        if (i_cmd.fl_rd) begin
            r_shadow_q <= shadow_mem[fl_addr];
        end
    end

    // Configuration registers; an area write whose field bits exceed the screen size keeps the old value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_width  <= WIDTH_W'(SCREEN_W);
            r_used_height <= HEIGHT_W'(SCREEN_H);
            r_front_level <= FRONT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USED_WIDTH: begin
                    if (i_cfg_data[WIDTH_W-1:0] <= WIDTH_W'(SCREEN_W)) begin
                        r_used_width <= i_cfg_data[WIDTH_W-1:0];
                    end
                end
                CFG_USED_HEIGHT: begin
                    if (i_cfg_data[HEIGHT_W-1:0] <= HEIGHT_W'(SCREEN_H)) begin
                        r_used_height <= i_cfg_data[HEIGHT_W-1:0];
                    end
                end
                CFG_FRONT_LEVEL: r_front_level <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture: target word, bit, value and range checks.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_addr      <= port_addr;
            r_bit       <= i_x_pos[BIT_W-1:0];
            r_on        <= (i_color >= r_front_level);
            r_inside    <= (i_x_pos < r_used_width) && (i_y_pos < POS_W'(r_used_height))
                        && ({1'b0, i_x_pos} < (POS_W+1)'(SCREEN_W))
                        && ({1'b0, i_y_pos} < (POS_W+1)'(SCREEN_H));
            r_rd_inside <= ({1'b0, i_x_pos} < (POS_W+1)'(SCREEN_W))
                        && ({1'b0, i_y_pos} < (POS_W+1)'(SCREEN_H));
        end
    end

    // Sweep counter for the clearing pass and the fill; wraps back to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_inc) begin
            r_sweep <= sweep_last ? '0 : r_sweep + ADDR_W'(1);
        end
    end

    // Flush scan: tile, line and word counters with difference tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcol         <= '0;
            r_trow         <= '0;
            r_line         <= '0;
            r_k            <= '0;
            r_line_diff    <= 1'b0;
            r_changed      <= 1'b0;
            r_flushed_once <= 1'b0;
        end else begin
            if (i_cmd.fl_start) begin
                r_tcol      <= '0;
                r_trow      <= '0;
                r_line      <= '0;
                r_k         <= '0;
                r_line_diff <= 1'b0;
                r_changed   <= 1'b0;
            end
            if (i_cmd.word_step) begin
                r_k <= word_last ? '0 : r_k + K_W'(1);
            end
            if (i_cmd.copy_wr) begin
                r_changed <= 1'b1;
            end
            // A finished line starts the next one with no difference seen.
            if (i_cmd.line_next) begin
                r_line      <= line_last ? '0 : r_line + LINE_W'(1);
                r_line_diff <= 1'b0;
            end else if (i_cmd.fl_cmp) begin
                r_line_diff <= diff_now;
            end
            if (i_cmd.tile_next) begin
                r_changed <= 1'b0;
                if (col_last) begin
                    r_tcol <= '0;
                    r_trow <= r_trow + TROW_W'(1);
                end else begin
                    r_tcol <= r_tcol + TCOL_W'(1);
                end
            end
            if (i_cmd.flush_done) begin
                r_flushed_once <= 1'b1;
            end
        end
    end

    // Frame words of the current line, kept for the shadow copy.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fl_cmp) begin
            r_buf[r_k] <= r_frame_q;
        end
    end

    // Output register: a result waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_load || i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_load) begin
            r_out_kind <= KIND_READ;
            r_out_tcol <= '0;
            r_out_trow <= '0;
            r_out_nw   <= 1'b0;
            r_out_bits <= r_rd_inside ? ROWBITS_W'(r_frame_q) : '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_out_kind <= KIND_TILE;
            r_out_tcol <= TIDX_W'(r_tcol);
            r_out_trow <= TIDX_W'(r_trow);
            r_out_nw   <= r_changed || !r_flushed_once;
            r_out_bits <= '0;
            r_out_last <= col_last && row_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_tile_col    = r_out_tcol;
    assign o_tile_row    = r_out_trow;
    assign o_needs_write = r_out_nw;
    assign o_row_bits    = r_out_bits;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

[rtl/mono_framebuffer_dirty_tiles.sv]
`default_nettype none
// ============================================================================
// mono_framebuffer_dirty_tiles: one-bit frame store with dirty-tile tracking
// Top level joining the sequencer and the datapath.
// ============================================================================
// One item is worked on at a time. After reset the block runs a clearing pass
// over the frame and shadow memories and holds o_stall high meanwhile;
// configuration writes are taken at any time. A pixel set reads the frame
// memory word and then writes it back, a row read reads the word and then
// waits for the output register, and a fill writes one memory word per cycle.
// A flush reads and compares each of the two words of a tile line, copies
// that line to the shadow when it differs, and hands over each tile report
// once the output register is free, for up to 16 tiles. The output register
// lets a finished result wait while the next item is taken.
module mono_framebuffer_dirty_tiles (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mfb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mfb_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // Input channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [mfb_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [mfb_pkg::POS_W-1:0]       i_x_pos,
    input  wire logic [mfb_pkg::POS_W-1:0]       i_y_pos,
    input  wire logic [mfb_pkg::COLOR_W-1:0]     i_color,
    // Output channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_kind,
    output logic [mfb_pkg::TIDX_W-1:0]           o_tile_col,
    output logic [mfb_pkg::TIDX_W-1:0]           o_tile_row,
    output logic                                 o_needs_write,
    output logic [mfb_pkg::ROWBITS_W-1:0]        o_row_bits,
    output logic                                 o_last
);
    import mfb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Registers accept every write transfer.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    mfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Storage and datapath.
    mfb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_color       (i_color),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_tile_col    (o_tile_col),
        .o_tile_row    (o_tile_row),
        .o_needs_write (o_needs_write),
        .o_row_bits    (o_row_bits),
        .o_last        (o_last),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule
`default_nettype wire

[rtl/mfb_check.sv]
`default_nettype none
// ============================================================================
// mfb_check: port-level checks of the one-bit frame store
// Watches the top level's ports and flags results or handshakes that break
// the block's rules; attached to the top level by a bind.
// ============================================================================
module mfb_check (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            o_stall,
    input  wire logic [mfb_pkg::FUNC_W-1:0]      i_func,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic                            o_kind,
    input  wire logic [mfb_pkg::TIDX_W-1:0]      o_tile_col,
    input  wire logic [mfb_pkg::TIDX_W-1:0]      o_tile_row,
    input  wire logic                            o_needs_write,
    input  wire logic [mfb_pkg::ROWBITS_W-1:0]   o_row_bits,
    input  wire logic                            o_last
);
    import mfb_pkg::*;

    // A read result carries only the row word and always closes its item.
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_READ)) |->
            (o_last && (o_tile_col == '0) && (o_tile_row == '0) && !o_needs_write))
        else $error("read result carries tile fields");

    // A tile report carries no row word.
    a_tile_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_TILE)) |-> (o_row_bits == '0))
        else $error("tile report carries row bits");

    // Every item other than a flush keeps the block busy after its transfer.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_func != FUNC_FLUSH)) |=> o_stall)
        else $error("input taken again right after a non-flush transfer");

    // A stalled result holds its valid, kind, row word and last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_kind) && $stable(o_row_bits) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind mono_framebuffer_dirty_tiles mfb_check u_mfb_check (.*);
`default_nettype wire
